// ===== design/csrp_pkg.sv =====
// status report parser package: states, segment kinds, prefix tables, queue entry
// no dependencies
`timescale 1ns / 1ps
package csrp_pkg;

  localparam int STATE_CHARS_DEF     = 8;
  localparam int FRACTION_DIGITS_DEF = 3;
  localparam int QUEUE_DEPTH_DEF     = 4;
  localparam int NUM_PREFIX          = 6;
  localparam int KEPT_NUMBERS        = 12;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_LINE = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    K_TEXT   = 4'd0,
    K_PREFIX = 4'd1,
    K_WPOS   = 4'd2,
    K_FS     = 4'd3,
    K_PN     = 4'd4,
    K_Q      = 4'd5,
    K_WCO    = 4'd6,
    K_OV     = 4'd7,
    K_IGNORE = 4'd8
  } seg_kind_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

  localparam logic [2:0] CNT_STOP = 3'd7;

  localparam logic [4:0] ITEM_STATE    = 5'd0;
  localparam logic [4:0] ITEM_WPOS     = 5'd1;
  localparam logic [4:0] ITEM_FS       = 5'd4;
  localparam logic [4:0] ITEM_PIN_BASE = 5'd6;
  localparam logic [4:0] ITEM_Q        = 5'd11;
  localparam logic [4:0] ITEM_WCO      = 5'd12;
  localparam logic [4:0] ITEM_OV       = 5'd15;

  // "WPos:", "FS:", "Pn:", "Q:", "WCO:", "Ov:"
  localparam logic [7:0] PFX_TEXT [NUM_PREFIX][5] = '{
    '{8'h57, 8'h50, 8'h6F, 8'h73, 8'h3A},
    '{8'h46, 8'h53, 8'h3A, 8'h00, 8'h00},
    '{8'h50, 8'h6E, 8'h3A, 8'h00, 8'h00},
    '{8'h51, 8'h3A, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h43, 8'h4F, 8'h3A, 8'h00},
    '{8'h4F, 8'h76, 8'h3A, 8'h00, 8'h00}
  };
  localparam logic [2:0] PFX_LEN [NUM_PREFIX] = '{3'd5, 3'd3, 3'd3, 3'd2, 3'd4, 3'd3};

  typedef struct packed {
    seg_kind_t       kind;
    logic [2:0][31:0] vals;
    logic [4:0]      pins;
    logic [63:0]     text;
  } entry_t;

  function automatic logic [13:0] pow10(input logic [2:0] k);
    logic [13:0] p;
    unique case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== design/csrp_if.sv =====
// byte input and update output channel interfaces
// depends on nothing
`timescale 1ns / 1ps
interface csrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface csrp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  changed_item;
  logic signed [31:0] number_value;
  logic [63:0] text_value;
  logic        last;
  modport source (output valid, output changed_item, output number_value,
                  output text_value, output last, input ready);
  modport sink (input valid, input changed_item, input number_value,
                input text_value, input last, output ready);
endinterface

// ===== design/cnc_status_report_parser_core.sv =====
// top level of the status report parser: front parser, segment queue, update emitter
// depends on csrp_pkg, csrp_if, csrp_front, csrp_queue, csrp_back
`timescale 1ns / 1ps
// Takes one status-line byte per cycle. A byte that closes a segment ('|' or '>')
// produces up to five updates; the back end sends them one per cycle while the
// output is ready. Finished segments wait in a QUEUE_DEPTH entry queue, and the
// input stalls only while that queue is full. The closing byte's entry is
// registered in the queue, and its first update in the back end's output register.
module cnc_status_report_parser_core import csrp_pkg::*; #(
  parameter int STATE_CHARS     = STATE_CHARS_DEF,
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  csrp_in_if.sink    in_if,
  csrp_out_if.source out_if
);

  logic   q_full, q_push, q_pop, q_head_valid;
  entry_t q_entry, q_head;

  csrp_front #(
    .STATE_CHARS    (STATE_CHARS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  csrp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_entry(q_head)
  );

  csrp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_head_valid),
    .head_entry(q_head),
    .pop       (q_pop),
    .out_if    (out_if)
  );

endmodule

// ===== design/csrp_front.sv =====
// front end: line and segment parser, pushes one entry per finished state, WPos, FS, Pn, Q, WCO or Ov segment
// depends on csrp_pkg and csrp_in_if
`timescale 1ns / 1ps
module csrp_front import csrp_pkg::*; #(
  parameter int STATE_CHARS     = STATE_CHARS_DEF,
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  csrp_in_if.sink in_if,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  localparam int          TLEN_W = $clog2(STATE_CHARS + 1);
  localparam logic [2:0]  FD     = 3'(FRACTION_DIGITS);
  localparam logic [TLEN_W-1:0] TMAX = TLEN_W'(STATE_CHARS);

  phase_t           phase_r, phase_nxt;
  seg_kind_t        kind_r, kind_nxt;
  logic [5:0]       cand_r, cand_nxt;
  logic [2:0]       ppos_r, ppos_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             sg_r, sg_nxt, pt_r, pt_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [2:0][31:0] vals_r, vals_nxt;
  logic [4:0]       pins_r, pins_nxt;
  logic             prevy_r, prevy_nxt;
  logic [63:0]      text_r, text_nxt;
  logic [TLEN_W-1:0] tlen_r, tlen_nxt;

  logic             accept, intk, numk, start_seg;
  seg_kind_t        start_kind;
  logic [7:0]       c;
  logic [2:0]       kexp;
  logic [63:0]      prod;
  logic [31:0]      scale_mag, fin_v;
  logic [35:0]      mac;
  logic [2:0][31:0] fin_vals;
  logic [5:0]       pnext;

  assign c           = in_if.rx_byte;
  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign intk        = (kind_r == K_Q) || (kind_r == K_OV);
  assign numk        = (kind_r == K_WPOS) || (kind_r == K_FS) || (kind_r == K_Q) ||
                       (kind_r == K_WCO) || (kind_r == K_OV);

  // scale to fixed fraction digits, saturating; Q and Ov values pass unscaled
  always_comb begin
    kexp = pt_r ? (FD - cnt_r) : FD;
    prod = {32'd0, acc_r} * {50'd0, pow10(kexp)};
    if (cnt_r == CNT_STOP || intk) scale_mag = acc_r;
    else if (prod[63:32] != 32'd0) scale_mag = 32'hFFFF_FFFF;
    else scale_mag = prod[31:0];
    if (sg_r) fin_v = scale_mag[31] ? 32'h8000_0000 : (32'd0 - scale_mag);
    else fin_v = scale_mag[31] ? 32'h7FFF_FFFF : scale_mag;
    mac = {1'b0, acc_r, 3'd0} + {3'd0, acc_r, 1'b0} + {32'd0, c[3:0]};
    fin_vals = vals_r;
    if (slot_r != 2'd3) fin_vals[slot_r] = fin_v;
  end

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    cand_nxt   = cand_r;
    ppos_nxt   = ppos_r;
    slot_nxt   = slot_r;
    acc_nxt    = acc_r;
    sg_nxt     = sg_r;
    pt_nxt     = pt_r;
    cnt_nxt    = cnt_r;
    vals_nxt   = vals_r;
    pins_nxt   = pins_r;
    prevy_nxt  = prevy_r;
    text_nxt   = text_r;
    tlen_nxt   = tlen_r;
    start_seg  = 1'b0;
    start_kind = K_PREFIX;
    q_push     = 1'b0;
    pnext      = '0;
    q_entry.kind = kind_r;
    q_entry.vals = fin_vals;
    q_entry.pins = pins_r;
    q_entry.text = text_r;

    if (accept) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (c == CH_LT) begin
            phase_nxt  = PH_LINE;
            start_seg  = 1'b1;
            start_kind = K_TEXT;
          end else if (c != CH_NL) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_LINE: begin
          if (c == CH_NL) begin
            phase_nxt = PH_WAIT;
          end else if (c == CH_BAR || c == CH_GT) begin
            q_push    = (kind_r == K_TEXT) || (kind_r == K_PN) || numk;
            start_seg = 1'b1;
            if (c == CH_GT) phase_nxt = PH_SKIP;
          end else if (kind_r == K_TEXT) begin
            if (cand_r != 6'd0) begin
              if (c == 8'd0) cand_nxt = 6'd0;
              else if (tlen_r < TMAX) begin
                for (int i = 0; i < 8; i++)
                  if (tlen_r == TLEN_W'(i)) text_nxt[8*i +: 8] = c;
                tlen_nxt = tlen_r + TLEN_W'(1);
              end
            end
          end else if (kind_r == K_PREFIX) begin
            for (int i = 0; i < NUM_PREFIX; i++)
              if (cand_r[i] && ppos_r < PFX_LEN[i] && PFX_TEXT[i][ppos_r] == c)
                pnext[i] = 1'b1;
            ppos_nxt = (ppos_r < 3'd7) ? ppos_r + 3'd1 : 3'd7;
            cand_nxt = pnext;
            if (pnext == 6'd0) kind_nxt = K_IGNORE;
            else
              for (int i = 0; i < NUM_PREFIX; i++)
                if (pnext[i] && {1'b0, PFX_LEN[i]} == {1'b0, ppos_r} + 4'd1)
                  kind_nxt = seg_kind_t'(4'(int'(K_WPOS) + i));
          end else if (kind_r == K_PN) begin
            if (c == CH_X) pins_nxt[0] = 1'b1;
            if (prevy_r && c == CH_ONE) pins_nxt[1] = 1'b1;
            if (prevy_r && c == CH_TWO) pins_nxt[2] = 1'b1;
            if (c == CH_Z) pins_nxt[3] = 1'b1;
            if (c == CH_H) pins_nxt[4] = 1'b1;
            prevy_nxt = (c == CH_Y);
          end else if (numk) begin
            if (c == CH_COMMA) begin
              if (slot_r != 2'd3) begin
                vals_nxt = fin_vals;
                slot_nxt = slot_r + 2'd1;
              end
              acc_nxt = '0;
              sg_nxt  = 1'b0;
              pt_nxt  = 1'b0;
              cnt_nxt = '0;
            end else if (cnt_r != CNT_STOP) begin
              if (c >= CH_ZERO && c <= CH_NINE) begin
                if (!pt_r || cnt_r < FD) begin
                  acc_nxt = (mac[35:32] != 4'd0) ? 32'hFFFF_FFFF : mac[31:0];
                  cnt_nxt = pt_r ? cnt_r + 3'd1 : 3'd1;
                end
              end else if ((c == CH_MINUS || c == CH_PLUS) && !pt_r && cnt_r == 3'd0) begin
                sg_nxt  = (c == CH_MINUS);
                cnt_nxt = 3'd1;
              end else if (c == CH_POINT && !pt_r && !intk) begin
                pt_nxt  = 1'b1;
                cnt_nxt = 3'd0;
              end else begin
                acc_nxt = scale_mag;
                cnt_nxt = CNT_STOP;
              end
            end
          end
        end
        default: begin
          if (c == CH_NL) phase_nxt = PH_WAIT;
        end
      endcase

      if (start_seg) begin
        kind_nxt  = start_kind;
        cand_nxt  = 6'h3F;
        ppos_nxt  = '0;
        slot_nxt  = '0;
        vals_nxt  = '0;
        pins_nxt  = '0;
        prevy_nxt = 1'b0;
        text_nxt  = '0;
        tlen_nxt  = '0;
        acc_nxt   = '0;
        sg_nxt    = 1'b0;
        pt_nxt    = 1'b0;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      kind_r  <= K_TEXT;
      cand_r  <= 6'h3F;
      ppos_r  <= '0;
      slot_r  <= '0;
      acc_r   <= '0;
      sg_r    <= 1'b0;
      pt_r    <= 1'b0;
      cnt_r   <= '0;
      vals_r  <= '0;
      pins_r  <= '0;
      prevy_r <= 1'b0;
      text_r  <= '0;
      tlen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      cand_r  <= cand_nxt;
      ppos_r  <= ppos_nxt;
      slot_r  <= slot_nxt;
      acc_r   <= acc_nxt;
      sg_r    <= sg_nxt;
      pt_r    <= pt_nxt;
      cnt_r   <= cnt_nxt;
      vals_r  <= vals_nxt;
      pins_r  <= pins_nxt;
      prevy_r <= prevy_nxt;
      text_r  <= text_nxt;
      tlen_r  <= tlen_nxt;
    end
  end

endmodule

// ===== design/csrp_queue.sv =====
// small flop queue of finished segments between front and back
// depends on csrp_pkg
`timescale 1ns / 1ps
module csrp_queue import csrp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop) count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

// ===== design/csrp_back.sv =====
// back end: compares a segment with the kept copy and emits one update a cycle while the output is ready
// depends on csrp_pkg and csrp_out_if
`timescale 1ns / 1ps
module csrp_back import csrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  csrp_out_if.source out_if
);

  logic [63:0]      kept_text_r, kept_text_nxt;
  logic [4:0]       kept_pins_r, kept_pins_nxt;
  logic [31:0]      kept_num_r [KEPT_NUMBERS];
  logic [31:0]      kept_num_nxt [KEPT_NUMBERS];

  logic             out_valid_r, out_valid_nxt;
  logic [4:0]       item_r, item_nxt;
  logic [31:0]      num_r, num_nxt;
  logic [63:0]      text_r, text_nxt;
  logic             last_r, last_nxt;

  logic [2:0][31:0] grp;
  logic [1:0]       grp_cnt;
  logic [3:0]       grp_idx;
  logic [4:0]       grp_item;
  logic [4:0]       mask;
  logic [2:0]       sel;
  logic             can_load;

  always_comb begin
    grp      = '0;
    grp_cnt  = 2'd0;
    grp_idx  = 4'd0;
    grp_item = ITEM_STATE;
    unique case (head_entry.kind)
      K_WPOS: begin
        grp = {kept_num_r[2], kept_num_r[1], kept_num_r[0]};
        grp_cnt = 2'd3; grp_idx = 4'd0; grp_item = ITEM_WPOS;
      end
      K_FS: begin
        grp = {32'd0, kept_num_r[4], kept_num_r[3]};
        grp_cnt = 2'd2; grp_idx = 4'd3; grp_item = ITEM_FS;
      end
      K_Q: begin
        grp = {32'd0, 32'd0, kept_num_r[5]};
        grp_cnt = 2'd1; grp_idx = 4'd5; grp_item = ITEM_Q;
      end
      K_WCO: begin
        grp = {kept_num_r[8], kept_num_r[7], kept_num_r[6]};
        grp_cnt = 2'd3; grp_idx = 4'd6; grp_item = ITEM_WCO;
      end
      K_OV: begin
        grp = {kept_num_r[11], kept_num_r[10], kept_num_r[9]};
        grp_cnt = 2'd3; grp_idx = 4'd9; grp_item = ITEM_OV;
      end
      default: ;
    endcase

    mask = '0;
    if (head_entry.kind == K_TEXT) begin
      mask[0] = (head_entry.text != kept_text_r);
    end else if (head_entry.kind == K_PN) begin
      mask = head_entry.pins ^ kept_pins_r;
    end else begin
      for (int j = 0; j < 3; j++)
        mask[j] = (2'(j) < grp_cnt) && (head_entry.vals[j] != grp[j]);
    end

    sel = 3'd0;
    for (int j = 4; j >= 0; j--)
      if (mask[j]) sel = 3'(j);
  end

  assign can_load = !out_valid_r || out_if.ready;

  always_comb begin
    kept_text_nxt = kept_text_r;
    kept_pins_nxt = kept_pins_r;
    kept_num_nxt  = kept_num_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    item_nxt      = item_r;
    num_nxt       = num_r;
    text_nxt      = text_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (head_valid && can_load) begin
      if (mask == '0) begin
        pop = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
        last_nxt      = $onehot(mask);
        pop           = $onehot(mask);
        text_nxt      = '0;
        num_nxt       = '0;
        if (head_entry.kind == K_TEXT) begin
          item_nxt      = ITEM_STATE;
          text_nxt      = head_entry.text;
          kept_text_nxt = head_entry.text;
        end else if (head_entry.kind == K_PN) begin
          item_nxt           = ITEM_PIN_BASE + {2'd0, sel};
          num_nxt            = {31'd0, head_entry.pins[sel]};
          kept_pins_nxt[sel] = head_entry.pins[sel];
        end else begin
          item_nxt = grp_item + {3'd0, sel[1:0]};
          num_nxt  = head_entry.vals[sel[1:0]];
          for (int n = 0; n < KEPT_NUMBERS; n++)
            if (4'(n) == grp_idx + {2'd0, sel[1:0]})
              kept_num_nxt[n] = head_entry.vals[sel[1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      kept_text_r <= '0;
      kept_pins_r <= '0;
      for (int n = 0; n < KEPT_NUMBERS; n++) kept_num_r[n] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      kept_text_r <= kept_text_nxt;
      kept_pins_r <= kept_pins_nxt;
      kept_num_r  <= kept_num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    num_r  <= num_nxt;
    text_r <= text_nxt;
    last_r <= last_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.changed_item = item_r;
  assign out_if.number_value = num_r;
  assign out_if.text_value   = text_r;
  assign out_if.last         = last_r;

endmodule

// ===== design/csrp_checker.sv =====
// port-level checks on the update channel, bound to the top level
// depends on cnc_status_report_parser_core
`timescale 1ns / 1ps
module csrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_item,
  input logic [31:0] out_number,
  input logic [63:0] out_text
);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item) && $stable(out_number)
      && $stable(out_text))
    else $error("update changed while stalled");

  a_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item <= 5'd17)
    else $error("item code out of range");

  a_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item != 5'd0 |-> out_text == 64'd0)
    else $error("text on a numeric update");

  a_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item == 5'd0 |-> out_number == 32'd0)
    else $error("number on a state update");

  a_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item >= 5'd6 && out_item <= 5'd10 |-> out_number[31:1] == 31'd0)
    else $error("pin update not 0 or 1");

endmodule

bind cnc_status_report_parser_core csrp_checker u_csrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_item  (out_if.changed_item),
  .out_number(out_if.number_value),
  .out_text  (out_if.text_value)
);
